FILE: design/lottery_slot_scheduler_defines.svh
// assertion helpers used by the top-level scheduler file
`ifndef LOTTERY_SLOT_SCHEDULER_DEFINES_SVH
`define LOTTERY_SLOT_SCHEDULER_DEFINES_SVH

// whenever ante holds in a cycle, cons holds in the same cycle
`define LSS_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// bad never holds at a clock edge
`define LSS_ASSERT_NEVER(label, clk, rst_n, bad, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
    else $error(msg);

`endif

FILE: design/lss_pkg.sv
`timescale 1ns / 1ps

package lss_pkg;

  // request and result field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned TICKET_W = 8;
  localparam int unsigned GRANT_W  = 32;
  localparam int unsigned DRAW_W   = 15;
  localparam int unsigned LCG_W    = 32;

  // draw value sits in bits 30:16 of the generator state
  localparam int unsigned DRAW_LSB = 16;

  localparam logic [LCG_W-1:0] LCG_MUL = 32'd1103515245;
  localparam logic [LCG_W-1:0] LCG_ADD = 32'd12345;

  // operation codes
  localparam logic [OP_W-1:0] OP_SET   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAW  = 2'd2;

  typedef struct packed {
    logic slot_set;
    logic slot_clear;
    logic walk_start;
    logic walk_step;
    logic pick_mode;
    logic lcg_mul;
    logic lcg_add;
    logic div_step;
    logic grant_rd;
    logic grant_wr;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic walk_end;
    logic hit;
    logic sum_zero;
    logic div_last;
  } status_t;

endpackage

FILE: design/lss_req_if.sv
`timescale 1ns / 1ps

interface lss_req_if import lss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SLOT_W-1:0]   slot;
  logic                runnable;
  logic [TICKET_W-1:0] ticket_count;

  modport source (output valid, output operation, output slot, output runnable,
                  output ticket_count, input ready);
  modport sink (input valid, input operation, input slot, input runnable,
                input ticket_count, output ready);
endinterface

FILE: design/lss_rsp_if.sv
`timescale 1ns / 1ps

interface lss_rsp_if import lss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [SLOT_W-1:0]  winner_slot;
  logic [GRANT_W-1:0] winner_grants;
  logic [DRAW_W-1:0]  draw_value;

  modport source (output valid, output found, output winner_slot, output winner_grants,
                  output draw_value, input ready);
  modport sink (input valid, input found, input winner_slot, input winner_grants,
                input draw_value, output ready);
endinterface

FILE: design/lss_ram.sv
`timescale 1ns / 1ps

module lss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: design/lss_ctrl.sv
`timescale 1ns / 1ps

module lss_ctrl import lss_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic [OP_W-1:0] req_op_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output cmd_t            cmd_o,
  input  status_t         status_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SUM      = 4'd1;
  localparam logic [3:0] S_LCG_MUL  = 4'd2;
  localparam logic [3:0] S_LCG_ADD  = 4'd3;
  localparam logic [3:0] S_DIV      = 4'd4;
  localparam logic [3:0] S_PICK     = 4'd5;
  localparam logic [3:0] S_GRANT_WR = 4'd6;
  localparam logic [3:0] S_RESULT   = 4'd7;

  logic [3:0] state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          case (req_op_i)
            OP_SET: begin
              cmd_o.slot_set = 1'b1;
            end
            OP_CLEAR: begin
              cmd_o.slot_clear = 1'b1;
            end
            OP_DRAW: begin
              cmd_o.walk_start = 1'b1;
              state_d          = S_SUM;
            end
            default: ;
          endcase
        end
      end
      S_SUM: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.walk_end) begin
          state_d = S_LCG_MUL;
        end
      end
      S_LCG_MUL: begin
        if (status_i.sum_zero) begin
          state_d = S_RESULT;
        end else begin
          cmd_o.lcg_mul = 1'b1;
          state_d       = S_LCG_ADD;
        end
      end
      S_LCG_ADD: begin
        cmd_o.lcg_add = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          cmd_o.walk_start = 1'b1;
          cmd_o.pick_mode  = 1'b1;
          state_d          = S_PICK;
        end
      end
      S_PICK: begin
        cmd_o.pick_mode = 1'b1;
        if (status_i.hit) begin
          cmd_o.grant_rd = 1'b1;
          state_d        = S_GRANT_WR;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_GRANT_WR: begin
        cmd_o.grant_wr = 1'b1;
        state_d        = S_RESULT;
      end
      S_RESULT: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.result_load = 1'b1;
          rsp_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

FILE: design/lss_datapath.sv
`timescale 1ns / 1ps

module lss_datapath import lss_pkg::*; #(
  parameter int unsigned SLOT_COUNT  = 64,
  parameter int unsigned TICKET_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                cfg_we_i,
  input  logic [LCG_W-1:0]    cfg_data_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic                runnable_i,
  input  logic [TICKET_W-1:0] ticket_count_i,
  output logic                found_o,
  output logic [SLOT_W-1:0]   winner_slot_o,
  output logic [GRANT_W-1:0]  winner_grants_o,
  output logic [DRAW_W-1:0]   draw_value_o
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned SUM_W = TICKET_BITS + IDX_W;
  localparam int unsigned DCNT_W = $clog2(DRAW_W);

  // slot table control
  logic [SLOT_COUNT-1:0]  flag_q;
  logic [SLOT_COUNT-1:0]  gvalid_q;
  logic [IDX_W-1:0]       slot_idx;
  logic                   slot_ok;
  logic                   tick_we;
  logic [TICKET_BITS-1:0] tick_wdata;
  logic [TICKET_BITS-1:0] tick_rdata;

  // walk
  logic [CNT_W-1:0] idx_q;
  logic             pend_q;
  logic [IDX_W-1:0] pend_idx_q;
  logic             walk_end;
  logic [SUM_W-1:0] tick_ext;
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] running_q;
  logic [SUM_W-1:0] running_nx;
  logic             hit_q;
  logic [IDX_W-1:0] winner_q;

  // generator and modulo
  logic [LCG_W-1:0]  lcg_q;
  logic [LCG_W-1:0]  prod_q;
  logic [LCG_W-1:0]  lcg_nx;
  logic [DRAW_W-1:0] draw_q;
  logic [DRAW_W-1:0] dvd_q;
  logic [SUM_W-1:0]  rem_q;
  logic [SUM_W:0]    rem_try;
  logic [SUM_W:0]    rem_diff;
  logic [DCNT_W-1:0] dcnt_q;

  // grant counters
  logic [GRANT_W-1:0] grant_rdata;
  logic [GRANT_W-1:0] grant_nx;
  logic [GRANT_W-1:0] grant_q;

  assign slot_idx   = IDX_W'(slot_i);
  assign slot_ok    = 32'(slot_i) < 32'(SLOT_COUNT);
  assign tick_we    = (cmd_i.slot_set || cmd_i.slot_clear) && slot_ok;
  assign tick_wdata = cmd_i.slot_set ? ticket_count_i[TICKET_BITS-1:0] : TICKET_BITS'(1);

  lss_ram #(
    .WIDTH (TICKET_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_tick_ram (
    .clk_i   (clk_i),
    .we_i    (tick_we),
    .waddr_i (slot_idx),
    .wdata_i (tick_wdata),
    .re_i    (cmd_i.walk_step),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (tick_rdata)
  );

  lss_ram #(
    .WIDTH (GRANT_W),
    .DEPTH (SLOT_COUNT)
  ) u_grant_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.grant_wr),
    .waddr_i (winner_q),
    .wdata_i (grant_nx),
    .re_i    (cmd_i.grant_rd),
    .raddr_i (winner_q),
    .rdata_o (grant_rdata)
  );

  assign walk_end   = idx_q == CNT_W'(SLOT_COUNT);
  assign tick_ext   = pend_q ? SUM_W'(tick_rdata) : '0;
  assign running_nx = running_q + tick_ext;

  assign lcg_nx = prod_q + LCG_ADD;

  // one restoring step of the modulo
  assign rem_try  = {rem_q, dvd_q[DRAW_W-1]};
  assign rem_diff = rem_try - {1'b0, sum_q};

  // a counter never written since its slot was cleared reads as zero
  assign grant_nx = (gvalid_q[winner_q] ? grant_rdata : '0) + GRANT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q   <= '0;
      gvalid_q <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
      sum_q    <= '0;
      lcg_q    <= LCG_W'(1);
      dcnt_q   <= '0;
    end else begin
      if (cmd_i.slot_set && slot_ok) begin
        flag_q[slot_idx] <= runnable_i;
      end
      if (cmd_i.slot_clear && slot_ok) begin
        flag_q[slot_idx]   <= 1'b0;
        gvalid_q[slot_idx] <= 1'b0;
      end
      if (cmd_i.grant_wr) begin
        gvalid_q[winner_q] <= 1'b1;
      end
      if (cfg_we_i) begin
        lcg_q <= cfg_data_i;
      end else if (cmd_i.lcg_add) begin
        lcg_q <= lcg_nx;
      end
      if (cmd_i.walk_start) begin
        idx_q  <= '0;
        pend_q <= 1'b0;
        hit_q  <= 1'b0;
        if (!cmd_i.pick_mode) begin
          sum_q <= '0;
        end
      end else if (cmd_i.walk_step) begin
        if (walk_end) begin
          pend_q <= 1'b0;
        end else begin
          idx_q  <= idx_q + CNT_W'(1);
          pend_q <= flag_q[idx_q[IDX_W-1:0]];
        end
        if (!cmd_i.pick_mode) begin
          sum_q <= sum_q + tick_ext;
        end else if (pend_q && (running_nx > rem_q)) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.lcg_add) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start && cmd_i.pick_mode) begin
      running_q <= '0;
    end else if (cmd_i.walk_step && cmd_i.pick_mode) begin
      running_q <= running_nx;
      if (pend_q && (running_nx > rem_q)) begin
        winner_q <= pend_idx_q;
      end
    end
    if (cmd_i.walk_step && !walk_end) begin
      pend_idx_q <= idx_q[IDX_W-1:0];
    end
    if (cmd_i.lcg_mul) begin
      prod_q <= lcg_q * LCG_MUL;
    end
    if (cmd_i.lcg_add) begin
      draw_q <= lcg_nx[DRAW_LSB +: DRAW_W];
      dvd_q  <= lcg_nx[DRAW_LSB +: DRAW_W];
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_diff[SUM_W] ? rem_try[SUM_W-1:0] : rem_diff[SUM_W-1:0];
    end
    if (cmd_i.grant_wr) begin
      grant_q <= grant_nx;
    end
    if (cmd_i.result_load) begin
      found_o         <= hit_q;
      winner_slot_o   <= hit_q ? SLOT_W'(winner_q) : '0;
      winner_grants_o <= hit_q ? grant_q : '0;
      draw_value_o    <= hit_q ? draw_q : '0;
    end
  end

  assign status_o.walk_end = walk_end;
  assign status_o.hit      = hit_q;
  assign status_o.sum_zero = sum_q == '0;
  assign status_o.div_last = dcnt_q == DCNT_W'(DRAW_W - 1);

endmodule

FILE: design/lottery_slot_scheduler.sv
`timescale 1ns / 1ps
`include "lottery_slot_scheduler_defines.svh"

// Lottery arbiter over SLOT_COUNT slots, each with a runnable flag, a ticket
// count and a 32-bit grant counter. Requests come in on req_i: set slot
// (flag and tickets), clear slot (one ticket, not runnable, counter zeroed),
// and draw. Set, clear and unused codes give no result. A draw gives one
// result on rsp_o. It walks the ticket memory once to add up the runnable
// tickets; with no runnable tickets the result has found low and all other
// fields zero and the generator stays put. Otherwise the 32-bit generator
// steps (multiply, then add), bits 30:16 are reduced modulo the sum by a
// bit-serial divider, and a second walk of the ticket memory finds the
// winner, whose counter is read and then bumped before the result register
// loads. Both walks go over the single-read-port ticket memory. req_i is
// ready only between requests; a finished result sits in an output
// register, so the next request can be taken while it waits. Writing
// cfg_we_i loads cfg_data_i straight into the generator state (reset state
// is one); write it only while no draw is in flight. No clearing pass is
// needed after reset.
module lottery_slot_scheduler import lss_pkg::*; #(
  parameter int unsigned SLOT_COUNT  = 64,
  parameter int unsigned TICKET_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lss_req_if.sink          req_i,
  lss_rsp_if.source        rsp_o,
  input  logic             cfg_we_i,
  input  logic [LCG_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // sequencer: decodes requests and steps the datapath through a draw
  lss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // slot tables, generator, modulo unit and result register
  lss_datapath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .TICKET_BITS (TICKET_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .slot_i          (req_i.slot),
    .runnable_i      (req_i.runnable),
    .ticket_count_i  (req_i.ticket_count),
    .found_o         (rsp_o.found),
    .winner_slot_o   (rsp_o.winner_slot),
    .winner_grants_o (rsp_o.winner_grants),
    .draw_value_o    (rsp_o.draw_value)
  );

  // a draw with no winner reports all fields zero
  `LSS_ASSERT_HOLDS(a_empty_result_zero, clk_i, rst_ni, rsp_o.valid && !rsp_o.found,
    rsp_o.winner_slot == '0 && rsp_o.winner_grants == '0 && rsp_o.draw_value == '0,
    "result without winner carries nonzero fields")

  // at most one datapath command other than walk_start and pick_mode is driven at a time
  `LSS_ASSERT_HOLDS(a_single_cmd, clk_i, rst_ni, 1'b1,
    $onehot0({cmd.slot_set, cmd.slot_clear, cmd.walk_step, cmd.lcg_mul, cmd.lcg_add,
              cmd.div_step, cmd.grant_rd, cmd.grant_wr, cmd.result_load}),
    "more than one datapath command at once")

  // a result is never loaded over one that has not been taken
  `LSS_ASSERT_HOLDS(a_load_when_free, clk_i, rst_ni, cmd.result_load,
    !rsp_o.valid || rsp_o.ready, "result register overwritten while still pending")

  // a winner can only be found when runnable tickets exist
  `LSS_ASSERT_NEVER(a_hit_needs_tickets, clk_i, rst_ni, status.hit && status.sum_zero,
    "winner found with zero ticket sum")

endmodule
